// ===== sv/hsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared constants and conversion functions for the half/single converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfc_pkg;

    localparam logic REQ_TO_HALF   = 1'b0;
    localparam logic REQ_TO_SINGLE = 1'b1;

    localparam logic [4:0]  H_EXP_MAX = 5'h1F;
    localparam logic [7:0]  S_EXP_MAX = 8'hFF;
    localparam logic [7:0]  BIAS_DIFF = 8'd112;

    // binary32 -> binary16, round to nearest even
    function automatic logic [15:0] to_half(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  ef;
        logic [22:0] fr;
        logic [9:0]  pay;
        logic [10:0] hf;
        logic [5:0]  he;
        logic        rb;
        logic        st;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] mant;
        logic [23:0] low_mask;
        logic [11:0] sub;
        logic [15:0] r;
        begin
            sgn = x[31];
            ef  = x[30:23];
            fr  = x[22:0];
            pay = fr[22:13];
            hf  = 11'd0;
            he  = 6'd0;
            rb  = 1'b0;
            st  = 1'b0;
            m   = {1'b1, fr};
            sh  = 5'd0;
            mant = 24'd0;
            low_mask = 24'd0;
            sub = 12'd0;
            if (ef == S_EXP_MAX)
            begin
                if (fr != 23'd0 && pay == 10'd0)
                    pay = 10'd1;
                r = {sgn, H_EXP_MAX, pay};
            end
            else if (ef > 8'd142)
            begin
                r = {sgn, H_EXP_MAX, 10'd0};
            end
            else if (ef >= 8'd113)
            begin
                he = 6'(ef - BIAS_DIFF);
                hf = {1'b0, fr[22:13]};
                rb = fr[12];
                st = fr[11:0] != 12'd0;
                if (rb && (st || hf[0]))
                    hf = hf + 11'd1;
                // carry out of fraction bumps the exponent (may give infinity)
                r = {sgn, 15'({he[4:0], 10'd0} + {4'd0, hf})};
            end
            else if (ef >= 8'd102)
            begin
                sh = 5'(8'd126 - ef);  // 14..24
                mant = m >> sh;
                rb = m[sh - 5'd1];
                low_mask = (24'd1 << (sh - 5'd1)) - 24'd1;
                st = (m & low_mask) != 24'd0;
                sub = {1'b0, mant[10:0]};
                if (rb && (st || mant[0]))
                    sub = sub + 12'd1;
                // a carry to 0x400 lands on the smallest normal
                r = {sgn, 4'd0, sub[10:0]};
            end
            else
            begin
                r = {sgn, 15'd0};
            end
            return r;
        end
    endfunction

    // binary16 -> binary32, exact
    function automatic logic [31:0] to_single(input logic [15:0] h);
        logic       sgn;
        logic [4:0] e;
        logic [9:0] fr;
        logic [3:0] lz;
        logic [9:0] nf;
        logic [31:0] r;
        begin
            sgn = h[15];
            e   = h[14:10];
            fr  = h[9:0];
            lz  = 4'd0;
            for (int i = 0; i < 10; i++)
                if (fr[i])
                    lz = 4'(9 - i);
            nf = fr << (lz + 4'd1);
            if (e == 5'd0)
            begin
                if (fr == 10'd0)
                    r = {sgn, 31'd0};
                else
                    r = {sgn, 8'(8'd113 - {4'd0, lz} - 8'd1), nf, 13'd0};
            end
            else if (e == H_EXP_MAX)
                r = {sgn, S_EXP_MAX, fr, 13'd0};
            else
                r = {sgn, 8'({3'd0, e} + BIAS_DIFF), fr, 13'd0};
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/hsfc_core.sv =====
// ----------------------------------------------------------------------------
// hsfc_core
// Combinational conversion between the input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfc_core (
    input  wire logic        req_type,
    input  wire logic [31:0] in_bits,
    output logic      [31:0] out_bits
);

    always_comb
    begin
        if (req_type == hsfc_pkg::REQ_TO_HALF)
            out_bits = {16'd0, hsfc_pkg::to_half(in_bits)};
        else
            out_bits = hsfc_pkg::to_single(in_bits[15:0]);
    end

endmodule

`default_nettype wire

// ===== sv/half_single_float_converter.sv =====
// ----------------------------------------------------------------------------
// half_single_float_converter
// binary32 <-> binary16 converter, one transfer per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel | ports                                   | dir
// in      | in_valid, in_stall, req_type, in_bits   | into block
// out     | out_valid, out_stall, out_bits          | out of block
//
// Input register, then result register.
// Sustains one transfer per clock while out_stall is low; conversion is one short pass of logic.
// rst_n clears the valid flags only.
// A stall at the output backs up through both stages; in_stall is high only
// when both stages hold data and the output is stalled.
`default_nettype none

module half_single_float_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [31:0] in_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] out_bits
);

    logic        a_valid_reg;
    logic        a_type_reg;
    logic [31:0] a_bits_reg;
    logic        r_valid_reg;
    logic [31:0] r_bits_reg;
    logic [31:0] conv;
    logic        r_load;
    logic        a_load;

    hsfc_core u_core (
        .req_type (a_type_reg),
        .in_bits  (a_bits_reg),
        .out_bits (conv)
    );

    assign r_load   = !r_valid_reg || !out_stall;
    assign a_load   = !a_valid_reg || r_load;
    assign in_stall = !a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
                a_valid_reg <= in_valid;
            if (r_load)
                r_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && in_valid)
        begin
            a_type_reg <= req_type;
            a_bits_reg <= in_bits;
        end
        if (r_load && a_valid_reg)
            r_bits_reg <= conv;
    end

    assign out_valid = r_valid_reg;
    assign out_bits  = r_bits_reg;

endmodule

`default_nettype wire
